FILE: design/ows_pkg.sv
// Package for the 1-Wire ROM search engine: action codes, item, result and
// search state types, and search constants. No dependencies.
package ows_pkg;

  localparam int unsigned ROM_W = 64;

  typedef enum logic [2:0] {
    ACT_RESTART = 3'd0,
    ACT_FAMILY  = 3'd1,
    ACT_SKIP    = 3'd2,
    ACT_BEGIN   = 3'd3,
    ACT_BIT     = 3'd4
  } act_t;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [6:0] ROM_BITS     = 7'd64;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] family_code;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    logic             send_command;
    logic             write_valid;
    logic             write_bit;
    logic             pass_done;
    logic             found;
    logic [ROM_W-1:0] rom_id;
    logic             last_device;
  } result_t;

  typedef struct packed {
    logic [ROM_W-1:0] rom;
    logic [6:0]       last_disc;
    logic [3:0]       last_fam_disc;
    logic             last_dev;
    logic [6:0]       bit_pos;
    logic [6:0]       last_zero;
    logic [7:0]       crc;
    logic             active;
  } state_t;

  // one bit-serial step of the reflected Dallas CRC-8
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic din);
    logic fb;
    fb = crc[0] ^ din;
    return {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
  endfunction

endpackage

FILE: design/ows_if.sv
// Channel interfaces for the 1-Wire ROM search engine: input word and
// result word, each with valid/ready. No dependencies.
interface ows_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] family_code;
  logic       presence;
  logic       id_bit;
  logic       complement_bit;

  modport source (output valid, action, family_code, presence, id_bit, complement_bit,
                  input ready);
  modport sink   (input valid, action, family_code, presence, id_bit, complement_bit,
                  output ready);
endinterface

interface ows_out_if;
  logic        valid;
  logic        ready;
  logic        send_command;
  logic        write_valid;
  logic        write_bit;
  logic        pass_done;
  logic        found;
  logic [63:0] rom_id;
  logic        last_device;

  modport source (output valid, send_command, write_valid, write_bit, pass_done, found,
                  rom_id, last_device, input ready);
  modport sink   (input valid, send_command, write_valid, write_bit, pass_done, found,
                  rom_id, last_device, output ready);
endinterface

FILE: design/ows_step.sv
// Search step logic: next search state and result word for one input word.
// Purely combinational. Depends on ows_pkg.
module ows_step (
  input  ows_pkg::item_t   item,
  input  ows_pkg::state_t  st,
  output ows_pkg::state_t  st_nxt,
  output ows_pkg::result_t res
);
  import ows_pkg::*;

  logic [5:0]       idx;
  logic             dir;
  logic [ROM_W-1:0] rom_upd;
  logic [7:0]       crc_upd;
  logic             ok;

  assign idx = st.bit_pos[5:0] - 6'd1;

  // direction choice for a bit pair: the id bit when the pair differs, else from the last discrepancy
  always_comb begin
    if (item.id_bit != item.complement_bit) begin
      dir = item.id_bit;
    end else if (st.bit_pos < st.last_disc) begin
      dir = st.rom[idx];
    end else begin
      dir = (st.bit_pos == st.last_disc);
    end
  end

  always_comb begin
    rom_upd      = st.rom;
    rom_upd[idx] = dir;
  end

  assign crc_upd = crc8_step(st.crc, dir);
  assign ok      = (crc_upd == 8'h00) && (rom_upd[7:0] != 8'h00);

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (item.action)
      ACT_RESTART: begin
        st_nxt.active        = 1'b0;
        st_nxt.bit_pos       = 7'd1;
        st_nxt.last_zero     = 7'd0;
        st_nxt.crc           = 8'h00;
        st_nxt.last_disc     = 7'd0;
        st_nxt.last_fam_disc = 4'd0;
        st_nxt.last_dev      = 1'b0;
      end
      ACT_FAMILY: begin
        st_nxt.active        = 1'b0;
        st_nxt.bit_pos       = 7'd1;
        st_nxt.last_zero     = 7'd0;
        st_nxt.crc           = 8'h00;
        st_nxt.rom           = {{(ROM_W-8){1'b0}}, item.family_code};
        st_nxt.last_disc     = ROM_BITS;
        st_nxt.last_fam_disc = 4'd0;
        st_nxt.last_dev      = 1'b0;
      end
      ACT_SKIP: begin
        st_nxt.active        = 1'b0;
        st_nxt.bit_pos       = 7'd1;
        st_nxt.last_zero     = 7'd0;
        st_nxt.crc           = 8'h00;
        st_nxt.last_disc     = {3'd0, st.last_fam_disc};
        st_nxt.last_fam_disc = 4'd0;
        if (st.last_fam_disc == 4'd0) begin
          st_nxt.last_dev = 1'b1;
        end
      end
      ACT_BEGIN: begin
        st_nxt.bit_pos   = 7'd1;
        st_nxt.last_zero = 7'd0;
        st_nxt.crc       = 8'h00;
        if (st.last_dev || !item.presence) begin
          st_nxt.active        = 1'b0;
          st_nxt.last_disc     = 7'd0;
          st_nxt.last_fam_disc = 4'd0;
          st_nxt.last_dev      = 1'b0;
          res.pass_done        = 1'b1;
        end else begin
          st_nxt.active    = 1'b1;
          res.send_command = 1'b1;
        end
      end
      ACT_BIT: begin
        if (st.active) begin
          if (item.id_bit && item.complement_bit) begin
            // nobody answered the slot
            st_nxt.active        = 1'b0;
            st_nxt.bit_pos       = 7'd1;
            st_nxt.last_zero     = 7'd0;
            st_nxt.crc           = 8'h00;
            st_nxt.last_disc     = 7'd0;
            st_nxt.last_fam_disc = 4'd0;
            st_nxt.last_dev      = 1'b0;
            res.pass_done        = 1'b1;
          end else begin
            st_nxt.rom      = rom_upd;
            st_nxt.crc      = crc_upd;
            res.write_valid = 1'b1;
            res.write_bit   = dir;
            if ((item.id_bit == item.complement_bit) && !dir) begin
              st_nxt.last_zero = st.bit_pos;
              if (st.bit_pos < FAMILY_LIMIT) begin
                st_nxt.last_fam_disc = st.bit_pos[3:0];
              end
            end
            if (st.bit_pos >= ROM_BITS) begin
              if (ok) begin
                st_nxt.last_disc = st_nxt.last_zero;
                if (st_nxt.last_zero == 7'd0) begin
                  st_nxt.last_dev = 1'b1;
                end
                res.found  = 1'b1;
                res.rom_id = rom_upd;
              end else begin
                st_nxt.last_disc     = 7'd0;
                st_nxt.last_fam_disc = 4'd0;
                st_nxt.last_dev      = 1'b0;
              end
              res.pass_done    = 1'b1;
              st_nxt.active    = 1'b0;
              st_nxt.bit_pos   = 7'd1;
              st_nxt.last_zero = 7'd0;
              st_nxt.crc       = 8'h00;
            end else begin
              st_nxt.bit_pos = st.bit_pos + 7'd1;
            end
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.last_device = st_nxt.last_dev;
  end

endmodule

FILE: design/ows_out_stage.sv
// Result register of the search engine: holds one result word until the
// sink takes it. Depends on ows_pkg and ows_out_if.
module ows_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  input  ows_pkg::result_t load_data,
  output logic             space,
  ows_out_if.source        out_ch
);
  import ows_pkg::*;

  logic    v_r;
  result_t d_r;

  // register is free when empty or being drained this cycle
  assign space = !v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (space) begin
      v_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load_valid) begin
      d_r <= load_data;
    end
  end

  assign out_ch.valid        = v_r;
  assign out_ch.send_command = d_r.send_command;
  assign out_ch.write_valid  = d_r.write_valid;
  assign out_ch.write_bit    = d_r.write_bit;
  assign out_ch.pass_done    = d_r.pass_done;
  assign out_ch.found        = d_r.found;
  assign out_ch.rom_id       = d_r.rom_id;
  assign out_ch.last_device  = d_r.last_device;

endmodule

FILE: design/one_wire_rom_search_engine.sv
// Top level of the 1-Wire ROM search engine: input register, search state,
// step logic and result register. Depends on ows_pkg, ows_if, ows_step, ows_out_stage.
//
//   channel  dir  handshake       word
//   in_ch    in   valid/ready     action, family_code, presence, id_bit, complement_bit
//   out_ch   out  valid/ready     send_command, write_valid, write_bit, pass_done,
//                                 found, rom_id, last_device
//
// A word sits in the input register, then the step logic updates the search
// state and loads the result register.
// Throughput is one word per cycle while the sink takes results; the combinational step logic sets it.
// Synchronous active-low reset: empty pipeline, cleared counters, bit position 1.
// A stalled result register holds the input register, and in_ch.ready drops
// only when both stages are full and the sink does not take the result.
module one_wire_rom_search_engine (
  input  logic      clk,
  input  logic      rst_n,
  ows_in_if.sink    in_ch,
  ows_out_if.source out_ch
);
  import ows_pkg::*;

  logic    s_v_r;
  item_t   item_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res;
  logic    space;
  logic    adv;
  logic    in_acc;

  // word moves from the input register into the result register
  assign adv         = s_v_r && space;
  assign in_ch.ready = !s_v_r || space;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_acc) begin
      s_v_r <= 1'b1;
    end else if (adv) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= '{action:         in_ch.action,
                  family_code:    in_ch.family_code,
                  presence:       in_ch.presence,
                  id_bit:         in_ch.id_bit,
                  complement_bit: in_ch.complement_bit};
    end
  end

  // search state, committed when the word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{rom:           '0,
                last_disc:     7'd0,
                last_fam_disc: 4'd0,
                last_dev:      1'b0,
                bit_pos:       7'd1,
                last_zero:     7'd0,
                crc:           8'h00,
                active:        1'b0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  ows_step u_step (
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  ows_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s_v_r),
    .load_data  (res),
    .space      (space),
    .out_ch     (out_ch)
  );

  // bit position stays in 1..64
  a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.bit_pos != 7'd0) && (st_r.bit_pos <= ROM_BITS))
    else $error("bit position out of range");

  // idle search sits at the first bit with a clean CRC
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.active |-> (st_r.bit_pos == 7'd1) && (st_r.crc == 8'h00))
    else $error("idle search state not cleared");

  // a found device always ends a pass
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> out_ch.pass_done && out_ch.write_valid)
    else $error("found without pass end");

  // a stalled input register keeps its word and the search state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r && !space |=> s_v_r && $stable(item_r) && $stable(st_r))
    else $error("stalled word or state changed");

  // search state moves only with a word
  a_state_move: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("search state changed without a word");

endmodule
